>>> hw/rtl/imupd_pkg.sv
// Shared types, constants and CRC/field-map functions for the IMU packet deframer.
package imupd_pkg;

   localparam logic [7:0] SYNC_RESET  = 8'hFA;
   localparam logic [6:0] STORE_FIRST = 7'd5;
   localparam logic [6:0] CRC_LEN     = 7'd81;
   localparam logic [6:0] BODY_LAST   = 7'd82;
   localparam logic [3:0] FIELD_LAST  = 4'd15;
   localparam logic [1:0] WORD_LAST   = 2'd3;

   // payload word write from front to back
   typedef struct packed {
      logic        en;
      logic        bank;
      logic [4:0]  word;
      logic [31:0] data;
   } mem_wr_type;

   // one finished packet waiting for the back end
   typedef struct packed {
      logic        good;
      logic        bank;
      logic [15:0] count;
   } desc_type;

   // read issued, waiting for memory data
   typedef struct packed {
      logic [3:0]  idx;
      logic        good;
      logic        wide;
      logic [15:0] count;
      logic        last;
   } issue_type;

   typedef struct packed {
      logic [3:0]  idx;
      logic [63:0] value;
      logic        good;
      logic [15:0] count;
      logic        last;
   } rsp_type;

   // CRC-16, poly 0x1021, bytewise form
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = {c[7:0], c[15:8]};
      x = x ^ {8'd0, b};
      x = x ^ {12'd0, x[7:4]};
      x = x ^ {x[3:0], 12'd0};
      x = x ^ {3'd0, x[7:0], 5'd0};
      return x;
   endfunction

   // first 32-bit payload word of each field
   function automatic logic [4:0] field_word(input logic [3:0] k);
      logic [4:0] w;
      case (k)
         4'd0:    w = 5'd0;
         4'd1:    w = 5'd1;
         4'd2:    w = 5'd2;
         4'd3:    w = 5'd3;
         4'd4:    w = 5'd4;
         4'd5:    w = 5'd5;
         4'd6:    w = 5'd6;
         4'd7:    w = 5'd7;
         4'd8:    w = 5'd9;
         4'd9:    w = 5'd11;
         4'd10:   w = 5'd13;
         4'd11:   w = 5'd14;
         4'd12:   w = 5'd15;
         4'd13:   w = 5'd16;
         4'd14:   w = 5'd17;
         4'd15:   w = 5'd18;
         default: w = 5'd0;
      endcase
      return w;
   endfunction

   // position fields span two words
   function automatic logic field_wide(input logic [3:0] k);
      logic r;
      case (k)
         4'd7, 4'd8, 4'd9: r = 1'b1;
         default:          r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/imu_packet_deframer.sv
// IMU packet deframer: byte stream in, CRC-checked field words out.
//
// req_*: one received byte per request. Bytes are dropped until one equals the
//   sync register (csr_*, reset 0xFA); the next 83 bytes are the packet body.
// rsp_*: per good packet 16 results (field index in tuser, raw little-endian
//   word and bad-packet count in tdata), tlast on the 16th. A CRC mismatch
//   gives one result with crc_good low, value 0, tlast high.
// Throughput: one byte per cycle while req_tready is high; results leave one per
//   cycle while rsp_tready is high, each via the queue, read and output registers.
// Two packets may wait on the back end (one payload memory bank each); req_tready
//   drops while both are pending and rises when the older one's last memory
//   read is issued.
// A stalled rsp side fills the two-entry output buffer, then holds the back end;
//   the front keeps taking bytes until both banks are in use.
// Reset: hunting, sync 0xFA, bad-packet counter 0, queues empty. No memory clear.
module imu_packet_deframer
   import imupd_pkg::*;
#(
   parameter int ERROR_COUNTER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,    // sync_value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // field_value[63:0], bad_packet_count[79:64]
   output logic [4:0]  rsp_tuser,   // field_index[3:0], crc_good[4]
   output logic        rsp_tlast
);

   mem_wr_type mem_wr;
   desc_type   desc, head;
   logic       desc_push, desc_pop, head_valid, q_full;
   rsp_type    rsp;

   assign csr_ready = 1'b1;

   imupd_front #(
      .ERROR_COUNTER_BITS(ERROR_COUNTER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_ready (req_tready),
      .q_full     (q_full),
      .mem_wr     (mem_wr),
      .desc_push  (desc_push),
      .desc       (desc)
   );

   imupd_desc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_desc  (desc),
      .pop        (desc_pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (q_full)
   );

   imupd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mem_wr     (mem_wr),
      .head_valid (head_valid),
      .head       (head),
      .pop        (desc_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (rsp)
   );

   assign rsp_tdata = {rsp.count, rsp.value};
   assign rsp_tuser = {rsp.good, rsp.idx};
   assign rsp_tlast = rsp.last;

   // error result is a lone zero result closing its run
   a_err_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[4] |-> rsp_tlast && rsp_tdata[63:0] == 64'd0
                                      && rsp_tuser[3:0] == 4'd0)
      else $error("error result malformed");

   // a good run ends exactly at the last field
   a_good_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[4] |-> rsp_tlast == (rsp_tuser[3:0] == FIELD_LAST))
      else $error("tlast misplaced in good run");

   // descriptor never pushed into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      desc_push |-> !q_full)
      else $error("descriptor queue overflow");

   // both banks held means no payload write may land
   a_bank_guard : assert property (@(posedge clock) disable iff (reset)
      q_full |-> !mem_wr.en)
      else $error("payload write while both banks busy");

endmodule

>>> hw/rtl/imupd_front.sv
// Front end: sync hunt, byte position, CRC, payload word assembly, bad-packet counter.
module imupd_front
   import imupd_pkg::*;
#(
   parameter int ERROR_COUNTER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic [7:0] csr_data,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       byte_ready,
   input  logic       q_full,
   output mem_wr_type mem_wr,
   output logic       desc_push,
   output desc_type   desc
);

   logic [7:0]  sync_ff, sync_in;
   logic        in_pkt_ff, in_pkt_in;
   logic [6:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [23:0] word_ff, word_in;
   logic        bank_ff, bank_in;
   logic [ERROR_COUNTER_BITS-1:0] bad_ff, bad_in, bad_inc;
   logic [ERROR_COUNTER_BITS+15:0] bad_ext;
   logic [6:0]  spos;
   logic        acc, good;

   assign byte_ready = !q_full;
   assign acc        = byte_valid && byte_ready;
   assign spos       = 7'(pos_ff - STORE_FIRST);
   assign good       = ({crc_hi_ff, byte_data} == crc_ff);
   assign bad_inc    = (&bad_ff) ? bad_ff : bad_ff + ERROR_COUNTER_BITS'(1);
   assign bad_ext    = {16'd0, (good ? bad_ff : bad_inc)};

   always_comb begin
      sync_in   = csr_valid ? csr_data : sync_ff;
      in_pkt_in = in_pkt_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_hi_in = crc_hi_ff;
      word_in   = word_ff;
      bank_in   = bank_ff;
      bad_in    = bad_ff;
      mem_wr    = '{en: 1'b0, bank: bank_ff, word: spos[6:2], data: {byte_data, word_ff}};
      desc_push = 1'b0;
      desc.good = good;
      desc.bank = bank_ff;
      desc.count = (bad_ext[ERROR_COUNTER_BITS+15:16] != '0) ? 16'hFFFF : bad_ext[15:0];
      if (acc) begin
         if (!in_pkt_ff) begin
            if (byte_data == sync_ff) begin
               in_pkt_in = 1'b1;
               pos_in    = '0;
               crc_in    = '0;
            end
         end else begin
            if (pos_ff < CRC_LEN) begin
               crc_in = crc16_byte(crc_ff, byte_data);
            end
            if (pos_ff >= STORE_FIRST && pos_ff < CRC_LEN) begin
               if (spos[1:0] == WORD_LAST) begin
                  mem_wr.en = 1'b1;
               end else begin
                  word_in = {byte_data, word_ff[23:8]};
               end
            end
            if (pos_ff == CRC_LEN) begin
               crc_hi_in = byte_data;
            end
            if (pos_ff == BODY_LAST) begin
               in_pkt_in = 1'b0;
               pos_in    = '0;
               crc_in    = '0;
               desc_push = 1'b1;
               bank_in   = !bank_ff;
               if (!good) begin
                  bad_in = bad_inc;
               end
            end else begin
               pos_in = 7'(pos_ff + 7'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= SYNC_RESET;
         in_pkt_ff <= 1'b0;
         pos_ff    <= '0;
         crc_ff    <= '0;
         crc_hi_ff <= '0;
         bank_ff   <= 1'b0;
         bad_ff    <= '0;
      end else begin
         sync_ff   <= sync_in;
         in_pkt_ff <= in_pkt_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_hi_ff <= crc_hi_in;
         bank_ff   <= bank_in;
         bad_ff    <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

>>> hw/rtl/imupd_desc_queue.sv
// Two-entry queue of finished packet descriptors between front and back.
module imupd_desc_queue
   import imupd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head,
   output logic     full
);

   desc_type   ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_valid = (cnt_ff != 2'd0);
   assign full       = (cnt_ff == 2'd2);
   assign head       = ent_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      cnt_in  = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= push_desc;
      end
   end

endmodule

>>> hw/rtl/imupd_back.sv
// Back end: double-banked payload memory, field sequencer and two-entry output buffer.
module imupd_back
   import imupd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mem_wr_type mem_wr,
   input  logic       head_valid,
   input  desc_type   head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_rsp
);

   logic [31:0] mem [64];
   logic [31:0] rd_lo_ff, rd_hi_ff;
   logic [4:0]  word_lo, word_hi;
   logic [3:0]  fld_ff, fld_in;
   issue_type   s1_ff, s1_in;
   logic        s1_vld_ff;
   rsp_type     buf_ff [2];
   rsp_type     fill;
   logic        wptr_ff, rptr_ff;
   logic [1:0]  cnt_ff, occ;
   logic        out_pop, issue;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_rsp   = buf_ff[rptr_ff];
   assign out_pop   = out_valid && out_ready;

   // slots taken once the in-flight read and this cycle's output are counted
   assign occ   = 2'(cnt_ff + {1'b0, s1_vld_ff} - {1'b0, out_pop});
   assign issue = head_valid && (occ < 2'd2);

   assign word_lo = field_word(fld_ff);
   assign word_hi = 5'(word_lo + 5'd1);

   always_comb begin
      fld_in = fld_ff;
      pop    = 1'b0;
      s1_in.idx   = head.good ? fld_ff : 4'd0;
      s1_in.good  = head.good;
      s1_in.wide  = field_wide(fld_ff);
      s1_in.count = head.count;
      s1_in.last  = !head.good || (fld_ff == FIELD_LAST);
      if (issue) begin
         if (!head.good || fld_ff == FIELD_LAST) begin
            pop    = 1'b1;
            fld_in = '0;
         end else begin
            fld_in = 4'(fld_ff + 4'd1);
         end
      end
   end

   always_comb begin
      fill.idx   = s1_ff.idx;
      fill.good  = s1_ff.good;
      fill.count = s1_ff.count;
      fill.last  = s1_ff.last;
      if (!s1_ff.good) begin
         fill.value = '0;
      end else if (s1_ff.wide) begin
         fill.value = {rd_hi_ff, rd_lo_ff};
      end else begin
         fill.value = {32'd0, rd_lo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[{mem_wr.bank, mem_wr.word}] <= mem_wr.data;
      end
      if (issue) begin
         rd_lo_ff <= mem[{head.bank, word_lo}];
         rd_hi_ff <= mem[{head.bank, word_hi}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fld_ff    <= '0;
         s1_vld_ff <= 1'b0;
         wptr_ff   <= 1'b0;
         rptr_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         fld_ff    <= fld_in;
         s1_vld_ff <= issue;
         wptr_ff   <= s1_vld_ff ? !wptr_ff : wptr_ff;
         rptr_ff   <= out_pop ? !rptr_ff : rptr_ff;
         cnt_ff    <= 2'(cnt_ff + {1'b0, s1_vld_ff} - {1'b0, out_pop});
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= s1_in;
      end
      if (s1_vld_ff) begin
         buf_ff[wptr_ff] <= fill;
      end
   end

endmodule

>>> test/imu_packet_deframer_checker.sv
// Scoreboard for the IMU packet deframer: predicts field results from accepted bytes.
`timescale 1ns / 100ps
module imu_packet_deframer_checker
   import imupd_pkg::*;
#(
   parameter int CNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,   // field_value[63:0], bad_packet_count[79:64]
   input  logic [4:0]  rsp_tuser,   // field_index[3:0], crc_good[4]
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);

   localparam int BODY_BYTES    = 83;
   localparam int CRC_BYTES     = 81;
   localparam int PAYLOAD_FIRST = 5;
   localparam int PAYLOAD_BYTES = 76;
   localparam int NUM_FIELDS    = 16;
   localparam int POS_FIRST     = 7;
   localparam int POS_LAST      = 9;
   localparam int REPORT_MAX    = 65535;
   localparam int MAX_SHOWN     = 10;

   logic [7:0]          sync_byte;
   logic                hunting;
   int                  body_pos;
   logic [15:0]         crc_run;
   logic [7:0]          crc_hi;
   logic [7:0]          payload [PAYLOAD_BYTES];
   logic [CNT_BITS-1:0] bad_packets;
   rsp_type             field_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // CRC-16/0x1021, one bit at a time, MSB first
   function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) begin
            r = {r[14:0], 1'b0} ^ 16'h1021;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] reported_count(input logic [CNT_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return (w > REPORT_MAX) ? 16'(REPORT_MAX) : w[15:0];
   endfunction

   task automatic close_packet(input logic [15:0] rx_crc);
      rsp_type r;
      int      off;
      int      len;
      if (rx_crc != crc_run) begin
         if (bad_packets != '1) begin
            bad_packets = bad_packets + CNT_BITS'(1);
         end
         r.idx   = '0;
         r.value = '0;
         r.good  = 1'b0;
         r.count = reported_count(bad_packets);
         r.last  = 1'b1;
         field_q.push_back(r);
      end else begin
         off = 0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            len     = (k >= POS_FIRST && k <= POS_LAST) ? 8 : 4;
            r.value = '0;
            // little-endian assembly
            for (int j = 0; j < len; j++) begin
               r.value[8*j +: 8] = payload[off + j];
            end
            r.idx   = 4'(k);
            r.good  = 1'b1;
            r.count = reported_count(bad_packets);
            r.last  = (k == NUM_FIELDS - 1);
            field_q.push_back(r);
            off += len;
         end
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      if (hunting) begin
         if (b == sync_byte) begin
            hunting  = 1'b0;
            body_pos = 0;
            crc_run  = '0;
         end
      end else begin
         if (body_pos < CRC_BYTES) begin
            crc_run = crc_update(crc_run, b);
         end
         if (body_pos >= PAYLOAD_FIRST && body_pos < PAYLOAD_FIRST + PAYLOAD_BYTES) begin
            payload[body_pos - PAYLOAD_FIRST] = b;
         end
         if (body_pos == CRC_BYTES) begin
            crc_hi = b;
         end
         if (body_pos < BODY_BYTES - 1) begin
            body_pos++;
         end else begin
            hunting  = 1'b1;
            body_pos = 0;
            close_packet({crc_hi, b});
            crc_run  = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         sync_byte   = SYNC_RESET;
         hunting     = 1'b1;
         body_pos    = 0;
         crc_run     = '0;
         crc_hi      = '0;
         bad_packets = '0;
         field_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.idx   = rsp_tuser[3:0];
            got.good  = rsp_tuser[4];
            got.value = rsp_tdata[63:0];
            got.count = rsp_tdata[79:64];
            got.last  = rsp_tlast;
            if (field_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN) begin
                  $display("%0t: unexpected result idx %0d value %h good %b count %0d last %b",
                           $time, got.idx, got.value, got.good, got.count, got.last);
               end
            end else begin
               want = field_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_SHOWN) begin
                     $display("%0t: expected idx %0d value %h good %b count %0d last %b",
                              $time, want.idx, want.value, want.good, want.count, want.last);
                     $display("%0t:      got idx %0d value %h good %b count %0d last %b",
                              $time, got.idx, got.value, got.good, got.count, got.last);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            sync_byte = csr_data;
         end
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
         end
      end
      pending = field_q.size();
   end

endmodule

>>> test/tb_imu_packet_deframer.sv
// Stimulus and verdict for the IMU packet deframer: framed byte packets, sync changes, stalls.
`timescale 1ns / 100ps
module tb_imu_packet_deframer
   import imupd_pkg::*;
();

   localparam int CNT_BITS     = 8;   // narrow counter; count is zero-extended on the way out
   localparam int BODY_BYTES   = 83;
   localparam int CRC_BYTES    = 81;
   localparam int NO_FLIP      = -1;
   localparam int DRAIN_CYCLES = 12;
   localparam int QUIET_LIMIT  = 2000;

   typedef enum {FILL_RANDOM, FILL_SYNCS, FILL_ZERO, FILL_ONES} fill_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   int          fail_count;
   int          waiting;
   int          quiet_cycles = 0;
   int          stall_left   = 0;
   bit          send_calm    = 1'b0;
   bit          rsp_calm     = 1'b0;
   logic [7:0]  sync_now     = SYNC_RESET;

   always #6 clock = ~clock;

   imu_packet_deframer #(
      .ERROR_COUNTER_BITS(CNT_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   imu_packet_deframer_checker #(
      .CNT_BITS(CNT_BITS)
   ) u_chk (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (waiting)
   );

   // mostly short, now and then long
   function automatic int pause_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 50);
   endfunction

   // shift-register form of the frame CRC, used to build good packets
   function automatic logic [15:0] frame_crc(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      repeat (8) begin
         x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
      end
      return x;
   endfunction

   function automatic logic [7:0] stray_byte(input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom);
      while (b == avoid) begin
         b = 8'($urandom);
      end
      return b;
   endfunction

   // result side: random stall runs unless calm
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 99) < 30) begin
            stall_left <= pause_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : pause_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input fill_type fill, input int flip_at);
      logic [7:0]  body [BODY_BYTES];
      logic [15:0] crc;
      crc = '0;
      for (int i = 0; i < CRC_BYTES; i++) begin
         case (fill)
            FILL_ZERO:  body[i] = 8'h00;
            FILL_ONES:  body[i] = 8'hFF;
            FILL_SYNCS: body[i] = $urandom_range(0, 1) ? sync_now : 8'($urandom);
            default:    body[i] = 8'($urandom);
         endcase
         crc = frame_crc(crc, body[i]);
      end
      body[CRC_BYTES]     = crc[15:8];
      body[CRC_BYTES + 1] = crc[7:0];
      if (flip_at != NO_FLIP) begin
         body[flip_at] = body[flip_at] ^ 8'(1 << $urandom_range(0, 7));
      end
      send_byte(sync_now);
      for (int i = 0; i < BODY_BYTES; i++) begin
         send_byte(body[i]);
      end
   endtask

   task automatic run_phase(input int packets);
      int       roll;
      fill_type fill;
      for (int p = 0; p < packets; p++) begin
         send_calm = ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 4)) send_byte(stray_byte(sync_now));
         end
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            fill = FILL_RANDOM;
         end else if (roll < 85) begin
            fill = FILL_SYNCS;
         end else if (roll < 93) begin
            fill = FILL_ZERO;
         end else begin
            fill = FILL_ONES;
         end
         send_packet(fill, ($urandom_range(0, 3) == 0) ?
                     int'($urandom_range(0, BODY_BYTES - 1)) : NO_FLIP);
      end
   endtask

   // hold requests until every result is out and the pipe has emptied
   task automatic drain();
      req_tvalid <= 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_sync(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      sync_now = v;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of the byte, sync inside a body, error on the low CRC byte
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_packet(FILL_SYNCS, NO_FLIP);
      send_packet(FILL_RANDOM, BODY_BYTES - 1);

      drain();
      write_sync(8'h00);
      run_phase(1);

      drain();
      write_sync(SYNC_RESET);
      run_phase(1);

      drain();
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
